// File: src/fpd_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Framed packet deframer package
// Shared codes for the deframer: phase encodings, frame status codes and
// the framing constants.
// ---------------------------------------------------------------------------
package fpd_pkg;

  // Framing constants
  localparam logic [7:0] START_BYTE = 8'h24;
  localparam logic [7:0] TYPE_BYTE  = 8'h0A;
  localparam logic [7:0] MIN_LENGTH = 8'd2;

  // Parser phase codes
  localparam logic [1:0] PH_HUNT = 2'd0;
  localparam logic [1:0] PH_TYPE = 2'd1;
  localparam logic [1:0] PH_LEN  = 2'd2;
  localparam logic [1:0] PH_BODY = 2'd3;

  // Frame status codes
  localparam logic [2:0] ST_NONE     = 3'd0;
  localparam logic [2:0] ST_GOOD     = 3'd1;
  localparam logic [2:0] ST_BAD_TYPE = 3'd2;
  localparam logic [2:0] ST_BAD_LEN  = 3'd3;
  localparam logic [2:0] ST_BAD_SUM  = 3'd4;

  // One tagged result
  typedef struct packed {
    logic [7:0] out_byte;
    logic       in_frame;
    logic       is_payload;
    logic [2:0] frame_status;
    logic       forward;
  } result_t;

endpackage

// File: src/fpd_in_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Deframer receive channel
// Valid/ready channel that carries one received byte per request.
// ---------------------------------------------------------------------------
interface fpd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

// File: src/fpd_out_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Deframer result channel
// Valid/ready channel that carries one echoed byte and its frame tags.
// ---------------------------------------------------------------------------
interface fpd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       in_frame;
  logic       is_payload;
  logic [2:0] frame_status;
  logic       forward;

  modport source (output valid, output out_byte, output in_frame, output is_payload,
                  output frame_status, output forward, input ready);
  modport sink   (input valid, input out_byte, input in_frame, input is_payload,
                  input frame_status, input forward, output ready);
endinterface

// File: src/framed_packet_deframer_unit.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Framed packet deframer
// Start byte / type / length / additive checksum deframer with byte tagging.
// ---------------------------------------------------------------------------
// The block takes received bytes and returns each one from an output
// register, tagged with frame membership, payload flag, frame status and a
// forward mark on every second good frame. Each request is parsed in the cycle
// it is taken, by a phase register and one 8-bit running sum, and the tagged
// byte is held in a single output register; a new request is taken whenever
// that register is empty or being drained, so while the result side does not
// stall the sustained rate is one byte per cycle; a stall holds the input side.
// ---------------------------------------------------------------------------
module framed_packet_deframer_unit
  import fpd_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  fpd_in_if.sink       rx_i,
  fpd_out_if.source    res_o
);

  logic [1:0] phase_q, phase_d;
  logic [7:0] sum_q, sum_d;
  logic [7:0] len_q, len_d;
  logic [7:0] pos_q, pos_d;
  logic       match_q, match_d;
  logic       toggle_q, toggle_d;

  logic       out_valid_q;
  result_t    out_q, res_d;

  logic       accept;
  logic [7:0] rx_b;
  logic [7:0] sum_at;

  assign rx_b     = rx_i.rx_byte;
  assign rx_i.ready = !out_valid_q || res_o.ready;
  assign accept   = rx_i.valid && rx_i.ready;
  assign sum_at   = len_q - MIN_LENGTH;

  // Parse one byte against the current phase
  always_comb begin
    phase_d  = phase_q;
    sum_d    = sum_q;
    len_d    = len_q;
    pos_d    = pos_q;
    match_d  = match_q;
    toggle_d = toggle_q;
    res_d.out_byte     = rx_b;
    res_d.in_frame     = 1'b1;
    res_d.is_payload   = 1'b0;
    res_d.frame_status = ST_NONE;
    res_d.forward      = 1'b0;
    unique case (phase_q)
      PH_HUNT: begin
        if (rx_b == START_BYTE) begin
          sum_d   = rx_b;
          pos_d   = '0;
          match_d = 1'b0;
          len_d   = '0;
          phase_d = PH_TYPE;
        end else begin
          res_d.in_frame = 1'b0;
        end
      end
      PH_TYPE: begin
        if (rx_b == TYPE_BYTE) begin
          sum_d   = sum_q + rx_b;
          phase_d = PH_LEN;
        end else begin
          res_d.frame_status = ST_BAD_TYPE;
          phase_d            = PH_HUNT;
        end
      end
      PH_LEN: begin
        if (rx_b < MIN_LENGTH) begin
          res_d.frame_status = ST_BAD_LEN;
          phase_d            = PH_HUNT;
        end else begin
          len_d   = rx_b;
          sum_d   = sum_q + rx_b;
          pos_d   = '0;
          phase_d = PH_BODY;
        end
      end
      PH_BODY: begin
        if (len_q < MIN_LENGTH) begin
          // stored length too short: drop the frame and hunt again
          res_d.frame_status = ST_BAD_LEN;
          phase_d            = PH_HUNT;
        end else if (pos_q < sum_at) begin
          res_d.is_payload = 1'b1;
          sum_d            = sum_q + rx_b;
          pos_d            = pos_q + 8'd1;
        end else if (pos_q == sum_at) begin
          match_d = (rx_b == sum_q);
          pos_d   = pos_q + 8'd1;
        end else begin
          // trailer: report the outcome and hunt again
          if (match_q) begin
            res_d.frame_status = ST_GOOD;
            res_d.forward      = toggle_q;
            toggle_d           = ~toggle_q;
          end else begin
            res_d.frame_status = ST_BAD_SUM;
          end
          phase_d = PH_HUNT;
        end
      end
      default: phase_d = PH_HUNT;
    endcase
  end

  // Advance parser state on each accepted request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_HUNT;
      sum_q    <= '0;
      len_q    <= '0;
      pos_q    <= '0;
      match_q  <= 1'b0;
      toggle_q <= 1'b0;
    end else if (accept) begin
      phase_q  <= phase_d;
      sum_q    <= sum_d;
      len_q    <= len_d;
      pos_q    <= pos_d;
      match_q  <= match_d;
      toggle_q <= toggle_d;
    end
  end

  // Hold the result until it is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (rx_i.ready) begin
      out_valid_q <= rx_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_q <= res_d;
    end
  end

  assign res_o.valid        = out_valid_q;
  assign res_o.out_byte     = out_q.out_byte;
  assign res_o.in_frame     = out_q.in_frame;
  assign res_o.is_payload   = out_q.is_payload;
  assign res_o.frame_status = out_q.frame_status;
  assign res_o.forward      = out_q.forward;

`ifndef SYNTHESIS
  // a forward mark only rides on a good frame end
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.forward) |-> (out_q.frame_status == ST_GOOD))
    else $error("forward set without a good frame end");

  // payload bytes always belong to a frame
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.is_payload) |-> out_q.in_frame)
    else $error("payload byte outside a frame");

  // the body is only entered with a legal length
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_BODY) |-> (len_q >= MIN_LENGTH))
    else $error("body phase with short length");

  // the good-frame toggle flips only on a good frame end
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (toggle_q != $past(toggle_q)) |->
      (out_valid_q && out_q.frame_status == ST_GOOD))
    else $error("toggle changed without a good frame");
`endif

endmodule

// File: tb/sv/tb_framed_packet_deframer_unit.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Framed packet deframer testbench
// Drives byte streams into the deframer and checks every tagged byte it
// returns against a cycle-free predictor of the parser. A short table of
// directed bytes covers the hunt, every error code, the shortest frame and
// forwarding. Random frames follow: mostly well-formed, with broken, truncated
// and noise sequences mixed in. Both channels idle at random throughout.
// ---------------------------------------------------------------------------
module tb_framed_packet_deframer_unit;
  import fpd_pkg::*;

  localparam int unsigned FRAMED_ITEMS = 1500;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned TIMEOUT_NS   = 5_000_000;
  localparam int unsigned PRINT_LIMIT  = 40;

  // Result-side stall patterns
  localparam logic [1:0] SINK_ALWAYS   = 2'd0;
  localparam logic [1:0] SINK_RANDOM   = 2'd1;
  localparam logic [1:0] SINK_PERIODIC = 2'd2;
  localparam logic [1:0] SINK_CHOKED   = 2'd3;

  // One row of the directed table; the tags are used only when typed is set
  typedef struct packed {
    logic [7:0] rx;
    logic       typed;
    logic       in_frame;
    logic       is_payload;
    logic [2:0] status;
    logic       fwd;
  } byte_row_t;

  localparam int unsigned NUM_ROWS = 25;

  logic clk;
  logic rst_n;

  fpd_in_if  rx_if ();
  fpd_out_if res_if ();

  framed_packet_deframer_unit DUT (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .rx_i   (rx_if),
    .res_o  (res_if)
  );

  // Predictor state
  logic [1:0] parse_phase;
  logic [7:0] frame_sum;
  logic [7:0] frame_len;
  logic [7:0] body_pos;
  logic       sum_ok;
  logic       good_parity;

  result_t     tagged_q[$];
  int unsigned mismatch_count;
  int unsigned framed_count;
  int unsigned burst_left;

  byte_row_t directed_rows [NUM_ROWS] = '{
    '{8'h00, 1'b1, 1'b0, 1'b0, ST_NONE,     1'b0},  // hunt, ignored
    '{8'h24, 1'b1, 1'b1, 1'b0, ST_NONE,     1'b0},  // start
    '{8'h0B, 1'b1, 1'b1, 1'b0, ST_BAD_TYPE, 1'b0},  // wrong type
    '{8'h24, 1'b1, 1'b1, 1'b0, ST_NONE,     1'b0},
    '{8'h0A, 1'b1, 1'b1, 1'b0, ST_NONE,     1'b0},
    '{8'h01, 1'b1, 1'b1, 1'b0, ST_BAD_LEN,  1'b0},  // length one
    '{8'h24, 1'b1, 1'b1, 1'b0, ST_NONE,     1'b0},
    '{8'h0A, 1'b1, 1'b1, 1'b0, ST_NONE,     1'b0},
    '{8'h00, 1'b1, 1'b1, 1'b0, ST_BAD_LEN,  1'b0},  // length zero
    '{8'h24, 1'b1, 1'b1, 1'b0, ST_NONE,     1'b0},  // shortest frame, no payload
    '{8'h0A, 1'b0, 1'b0, 1'b0, ST_NONE,     1'b0},
    '{8'h02, 1'b0, 1'b0, 1'b0, ST_NONE,     1'b0},
    '{8'h30, 1'b0, 1'b0, 1'b0, ST_NONE,     1'b0},
    '{8'hFF, 1'b0, 1'b0, 1'b0, ST_NONE,     1'b0},  // first good end
    '{8'h24, 1'b1, 1'b1, 1'b0, ST_NONE,     1'b0},  // one payload byte of 0xFF
    '{8'h0A, 1'b0, 1'b0, 1'b0, ST_NONE,     1'b0},
    '{8'h03, 1'b0, 1'b0, 1'b0, ST_NONE,     1'b0},
    '{8'hFF, 1'b0, 1'b0, 1'b0, ST_NONE,     1'b0},
    '{8'h30, 1'b0, 1'b0, 1'b0, ST_NONE,     1'b0},
    '{8'h00, 1'b0, 1'b0, 1'b0, ST_NONE,     1'b0},  // second good end, forwarded
    '{8'h24, 1'b1, 1'b1, 1'b0, ST_NONE,     1'b0},
    '{8'h0A, 1'b0, 1'b0, 1'b0, ST_NONE,     1'b0},
    '{8'h02, 1'b0, 1'b0, 1'b0, ST_NONE,     1'b0},
    '{8'h00, 1'b0, 1'b0, 1'b0, ST_NONE,     1'b0},  // wrong checksum
    '{8'h24, 1'b1, 1'b1, 1'b0, ST_BAD_SUM,  1'b0}   // trailer equal to start byte
  };

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog
  initial begin
    #(TIMEOUT_NS);
    $display("tb_framed_packet_deframer_unit: FAIL");
    $finish;
  end

  // Parse one byte, advance the predictor state and return its tags
  function automatic result_t deframe_byte(input logic [7:0] b);
    result_t    r;
    logic [7:0] sum_pos;
    r          = '0;
    r.out_byte = b;
    sum_pos    = frame_len - MIN_LENGTH;
    case (parse_phase)
      PH_HUNT: begin
        if (b == START_BYTE) begin
          r.in_frame  = 1'b1;
          frame_sum   = b;
          body_pos    = '0;
          sum_ok      = 1'b0;
          frame_len   = '0;
          parse_phase = PH_TYPE;
        end
      end
      PH_TYPE: begin
        r.in_frame = 1'b1;
        if (b == TYPE_BYTE) begin
          frame_sum   = frame_sum + b;
          parse_phase = PH_LEN;
        end else begin
          r.frame_status = ST_BAD_TYPE;
          parse_phase    = PH_HUNT;
        end
      end
      PH_LEN: begin
        r.in_frame = 1'b1;
        if (b < MIN_LENGTH) begin
          r.frame_status = ST_BAD_LEN;
          parse_phase    = PH_HUNT;
        end else begin
          frame_len   = b;
          frame_sum   = frame_sum + b;
          body_pos    = '0;
          parse_phase = PH_BODY;
        end
      end
      default: begin
        r.in_frame = 1'b1;
        if (body_pos < sum_pos) begin
          r.is_payload = 1'b1;
          frame_sum    = frame_sum + b;
          body_pos     = body_pos + 8'd1;
        end else if (body_pos == sum_pos) begin
          sum_ok   = (b == frame_sum);
          body_pos = body_pos + 8'd1;
        end else begin
          if (sum_ok) begin
            r.frame_status = ST_GOOD;
            r.forward      = good_parity;
            good_parity    = ~good_parity;
          end else begin
            r.frame_status = ST_BAD_SUM;
          end
          parse_phase = PH_HUNT;
        end
      end
    endcase
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatch_count++;
    if (mismatch_count <= PRINT_LIMIT)
      $display("%0t ns: %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
  endtask

  // Offer one request, idling between bursts, and log its tags once taken
  task automatic send_byte(input logic [7:0] b, input logic typed, input result_t typed_res);
    result_t predicted;
    if (burst_left == 0) begin
      rx_if.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 8);
    end
    rx_if.valid   <= 1'b1;
    rx_if.rx_byte <= b;
    do @(posedge clk); while (!rx_if.ready);
    burst_left--;
    predicted = deframe_byte(b);
    if (predicted.in_frame) framed_count++;
    tagged_q.push_back(typed ? typed_res : predicted);
  endtask

  // Hold the sender until every outstanding result has come back
  task automatic wait_for_drain();
    rx_if.valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (tagged_q.size() != 0);
  endtask

  // One random sequence: noise, a broken header, or a frame that may be
  // truncated or carry a wrong checksum
  task automatic send_random_frame();
    int unsigned kind;
    int unsigned n_payload;
    logic [7:0]  len;
    logic [7:0]  sum;
    logic [7:0]  b;
    kind = $urandom_range(0, 99);
    if (kind < 10) begin
      repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)), 1'b0, '0);
    end else if (kind < 16) begin
      send_byte(START_BYTE, 1'b0, '0);
      b = 8'($urandom_range(0, 255));
      if (b == TYPE_BYTE) b = START_BYTE;
      send_byte(b, 1'b0, '0);
    end else if (kind < 22) begin
      send_byte(START_BYTE, 1'b0, '0);
      send_byte(TYPE_BYTE, 1'b0, '0);
      send_byte(8'($urandom_range(0, 1)), 1'b0, '0);
    end else begin
      if ($urandom_range(0, 59) == 0)
        len = ($urandom_range(0, 1) == 0) ? 8'hFF : 8'($urandom_range(100, 254));
      else
        len = 8'($urandom_range(2, 12));
      sum = START_BYTE + TYPE_BYTE + len;
      send_byte(START_BYTE, 1'b0, '0);
      send_byte(TYPE_BYTE, 1'b0, '0);
      send_byte(len, 1'b0, '0);
      // a truncated frame stops early and lets the next bytes run into its body
      n_payload = (kind < 27) ? $urandom_range(0, len - 2) : len - 2;
      repeat (n_payload) begin
        b   = 8'($urandom_range(0, 255));
        sum = sum + b;
        send_byte(b, 1'b0, '0);
      end
      if (kind >= 27) begin
        b = (kind < 37) ? sum ^ 8'($urandom_range(1, 255)) : sum;
        send_byte(b, 1'b0, '0);
        send_byte(8'($urandom_range(0, 255)), 1'b0, '0);
      end
    end
  endtask

  // Result side: switch at random between stall patterns
  initial begin
    logic [1:0]  sink_mode;
    int unsigned mode_left;
    int unsigned cyc;
    res_if.ready = 1'b0;
    sink_mode    = SINK_ALWAYS;
    mode_left    = 0;
    cyc          = 0;
    forever begin
      @(posedge clk);
      cyc++;
      if (mode_left == 0) begin
        sink_mode = 2'($urandom_range(0, 3));
        mode_left = $urandom_range(50, 400);
      end
      mode_left--;
      case (sink_mode)
        SINK_ALWAYS:   res_if.ready <= 1'b1;
        SINK_RANDOM:   res_if.ready <= ($urandom_range(0, 3) != 0);
        SINK_PERIODIC: res_if.ready <= (cyc % 4 != 3);
        default:       res_if.ready <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  // Check each returned byte against the oldest prediction
  always @(posedge clk) begin
    result_t want;
    if (rst_n && res_if.valid && res_if.ready) begin
      if (tagged_q.size() == 0) begin
        report_mismatch("result with nothing outstanding", res_if.out_byte, 0);
      end else begin
        want = tagged_q.pop_front();
        if (res_if.out_byte !== want.out_byte)
          report_mismatch("out_byte", res_if.out_byte, want.out_byte);
        if (res_if.in_frame !== want.in_frame)
          report_mismatch("in_frame", res_if.in_frame, want.in_frame);
        if (res_if.is_payload !== want.is_payload)
          report_mismatch("is_payload", res_if.is_payload, want.is_payload);
        if (res_if.frame_status !== want.frame_status)
          report_mismatch("frame_status", res_if.frame_status, want.frame_status);
        if (res_if.forward !== want.forward)
          report_mismatch("forward", res_if.forward, want.forward);
      end
    end
  end

  // Stimulus
  initial begin
    result_t typed_res;
    rst_n          = 1'b0;
    rx_if.valid    = 1'b0;
    rx_if.rx_byte  = '0;
    mismatch_count = 0;
    framed_count   = 0;
    burst_left     = 0;
    parse_phase    = PH_HUNT;
    frame_sum      = '0;
    frame_len      = '0;
    body_pos       = '0;
    sum_ok         = 1'b0;
    good_parity    = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Walk the directed table
    foreach (directed_rows[i]) begin
      typed_res = {directed_rows[i].rx, directed_rows[i].in_frame, directed_rows[i].is_payload,
                   directed_rows[i].status, directed_rows[i].fwd};
      send_byte(directed_rows[i].rx, directed_rows[i].typed, typed_res);
    end
    wait_for_drain();

    // Random frames, with an occasional full drain
    while (framed_count < FRAMED_ITEMS) begin
      send_random_frame();
      if ($urandom_range(0, 29) == 0) wait_for_drain();
    end
    rx_if.valid <= 1'b0;

    do @(posedge clk); while (tagged_q.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && tagged_q.size() == 0) begin
      $display("tb_framed_packet_deframer_unit: PASS");
    end else begin
      $display("tb_framed_packet_deframer_unit: FAIL");
    end
    $finish;
  end

endmodule
